// ----- src/tcgr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared constants, register indexes and controller/datapath interface types
// for the text console glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

    // Text grid and font geometry.
    localparam int TEXT_COLUMNS = 60;
    localparam int TEXT_ROWS    = 34;
    localparam int GLYPH_COUNT  = 96;
    localparam int GLYPH_LINES  = 8;
    localparam int STORE_DEPTH  = 768;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int CURSOR_W     = 6;
    localparam int COLOR_W      = 16;
    localparam int COORD_W      = 9;

    // Register reset values.
    localparam logic [COLOR_W-1:0] FG_RESET = 16'hA4FF;
    localparam logic [COLOR_W-1:0] BG_RESET = 16'h421B;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 1'd1;

    // Item operation codes.
    localparam logic OP_LOAD_ROW = 1'b0;
    localparam logic OP_PUT_CHAR = 1'b1;

    // Character codes of interest.
    localparam logic [7:0] CHAR_LF         = 8'd10;
    localparam logic [7:0] CHAR_CR         = 8'd13;
    localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
    localparam logic [7:0] LAST_PRINTABLE  = 8'd127;

    // Eight pixel colours of one glyph row, pixel 0 in element 0.
    typedef logic [7:0][COLOR_W-1:0] row_colors_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;      // register the character of the accepted item
        logic       sweep_we;     // write zero at the sweep address
        logic       load_we;      // write the accepted font row
        logic       issue_row;    // read one glyph row into the result stage
        logic       issue_clear;  // put a clear-screen result into the stage
        logic [2:0] row;          // glyph row being issued
        logic       last;         // issued result is the item's final one
        logic       advance;      // step the cursor one column
        logic       newline;      // move the cursor to the next row
    } tcgr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_last;  // sweep address is at the final entry
        logic stage_free;  // result stage can take an issue this cycle
        logic col_last;    // cursor is in the final column
        logic row_last;    // cursor is in the final row
    } tcgr_status_t;

endpackage
`default_nettype wire

// ----- src/text_console_glyph_renderer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_top
// Text console renderer with a loadable 8x8 font for 96 glyphs.
//
// Input channel (s_*): one item either loads one font row (op 0) or puts a
// character (op 1). Result channel (m_*): one pixel row of eight colours per
// result, or a clear-screen result; m_last marks an item's final result.
// Configuration channel (cfg_*): index 0 is the foreground colour, index 1
// the background colour; a write is taken in the cycle it is offered.
// A printable character occupies the block until its final glyph row, and
// any screen clear, has been issued: after acceptance one glyph row is read
// per cycle while the result stage is free, limited by the single port of
// the font store. Font loads, line breaks and other codes need only their
// acceptance, and a clear-screen result when they clear the screen.
// After reset a sweep clears the font store's 768 entries, one entry per
// cycle, during which s_ready stays low; colours take their reset values.
// When the receiver stalls, the output register and one stage behind it
// fill, and the controller waits before reading the next glyph row.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_top
    import tcgr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_op,
    input  wire logic [7:0]           s_char_code,
    input  wire logic [6:0]           s_glyph_index,
    input  wire logic [2:0]           s_glyph_row,
    input  wire logic [7:0]           s_glyph_bits,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [COORD_W-1:0]        m_pixel_x,
    output logic [COORD_W-1:0]        m_pixel_y,
    output logic [COLOR_W-1:0]        m_color0,
    output logic [COLOR_W-1:0]        m_color1,
    output logic [COLOR_W-1:0]        m_color2,
    output logic [COLOR_W-1:0]        m_color3,
    output logic [COLOR_W-1:0]        m_color4,
    output logic [COLOR_W-1:0]        m_color5,
    output logic [COLOR_W-1:0]        m_color6,
    output logic [COLOR_W-1:0]        m_color7,
    output logic                      m_clear_screen,
    output logic                      m_last,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COLOR_W-1:0]   cfg_data
);

    tcgr_cmd_t    cmd;
    tcgr_status_t status;
    row_colors_t  colors;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    tcgr_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_char_code (s_char_code),
        .status      (status),
        .cmd         (cmd)
    );

    tcgr_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_char_code    (s_char_code),
        .s_glyph_index  (s_glyph_index),
        .s_glyph_row    (s_glyph_row),
        .s_glyph_bits   (s_glyph_bits),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_colors       (colors),
        .m_clear_screen (m_clear_screen),
        .m_last         (m_last)
    );

    // Break the row colours out to one port per pixel.
    assign m_color0 = colors[0];
    assign m_color1 = colors[1];
    assign m_color2 = colors[2];
    assign m_color3 = colors[3];
    assign m_color4 = colors[4];
    assign m_color5 = colors[5];
    assign m_color6 = colors[6];
    assign m_color7 = colors[7];

    // An issue only happens when the result stage can take it.
    a_issue_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.issue_row || cmd.issue_clear) |-> status.stage_free)
        else $error("result issued while the stage is occupied");

    // The font store has one port: no write together with a glyph read.
    a_single_port: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.sweep_we || cmd.load_we) |-> !cmd.issue_row)
        else $error("font store written and read in the same cycle");

    // No item is taken while the font store is being cleared.
    a_sweep_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sweep_we |-> !s_ready)
        else $error("item accepted during the font store sweep");

    // A clear-screen result always carries zero coordinates.
    a_clear_coords: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_clear_screen) |-> (m_pixel_x == '0 && m_pixel_y == '0))
        else $error("clear-screen result with non-zero coordinates");

endmodule
`default_nettype wire

// ----- src/tcgr_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcgr_ctrl
// Controller: sequences the font store sweep after reset, the eight glyph
// rows of a printable character and the clear-screen result on row overflow.
// ----------------------------------------------------------------------------
module tcgr_ctrl
    import tcgr_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic         s_op,
    input  wire logic [7:0]   s_char_code,
    input  wire tcgr_status_t status,
    output tcgr_cmd_t         cmd
);

    localparam logic [1:0] ST_SWEEP = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_ROWS  = 2'd2;
    localparam logic [1:0] ST_CLEAR = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [2:0] row_reg, row_next;
    logic       accept;
    logic       is_newline;
    logic       is_print;
    logic       wrap_clear;

    // The input is ready exactly in the idle state.
    assign accept     = s_valid && (state_reg == ST_IDLE);
    assign is_newline = s_char_code inside {CHAR_LF, CHAR_CR};
    assign is_print   = s_char_code inside {[FIRST_PRINTABLE:LAST_PRINTABLE]};
    // A column step from the final cell of the final row overflows the screen.
    assign wrap_clear = status.col_last && status.row_last;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.row    = row_reg;
        case (state_reg)
            ST_SWEEP: begin
                cmd.sweep_we = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    cmd.capture = 1'b1;
                    if (s_op == OP_LOAD_ROW) begin
                        cmd.load_we = 1'b1;
                    end else if (is_newline) begin
                        cmd.newline = 1'b1;
                        if (status.row_last) begin
                            state_next = ST_CLEAR;
                        end
                    end else if (is_print) begin
                        row_next   = 3'd0;
                        state_next = ST_ROWS;
                    end else begin
                        cmd.advance = 1'b1;
                        if (wrap_clear) begin
                            state_next = ST_CLEAR;
                        end
                    end
                end
            end
            ST_ROWS: begin
                if (status.stage_free) begin
                    cmd.issue_row = 1'b1;
                    cmd.last      = (row_reg == 3'd7) && !wrap_clear;
                    row_next      = row_reg + 3'd1;
                    if (row_reg == 3'd7) begin
                        // The cursor moves on as the final row leaves.
                        cmd.advance = 1'b1;
                        state_next  = wrap_clear ? ST_CLEAR : ST_IDLE;
                    end
                end
            end
            ST_CLEAR: begin
                if (status.stage_free) begin
                    cmd.issue_clear = 1'b1;
                    cmd.last        = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SWEEP;
            row_reg   <= 3'd0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/tcgr_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcgr_datapath
// Datapath: colour registers, text cursor, font store memory, one result
// stage behind the memory read and the output register.
// ----------------------------------------------------------------------------
module tcgr_datapath
    import tcgr_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire tcgr_cmd_t              cmd,
    output tcgr_status_t                status,
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [COLOR_W-1:0]     cfg_data,
    input  wire logic [7:0]             s_char_code,
    input  wire logic [6:0]             s_glyph_index,
    input  wire logic [2:0]             s_glyph_row,
    input  wire logic [7:0]             s_glyph_bits,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [COORD_W-1:0]          m_pixel_x,
    output logic [COORD_W-1:0]          m_pixel_y,
    output row_colors_t                 m_colors,
    output logic                        m_clear_screen,
    output logic                        m_last
);

    logic [COLOR_W-1:0]  fg_reg, bg_reg;
    logic [CURSOR_W-1:0] col_reg, col_next;
    logic [CURSOR_W-1:0] row_reg, row_next;
    logic [7:0]          code_reg;
    logic [ADDR_W-1:0]   sweep_reg;
    logic [7:0]          mem [0:STORE_DEPTH-1];
    logic [7:0]          rd_data_reg;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic [6:0]          glyph_slot;
    logic                mem_we;
    logic [7:0]          mem_wdata;

    // Result stage between the memory read and the output register.
    logic               st_valid_reg;
    logic               st_clear_reg;
    logic               st_last_reg;
    logic [COORD_W-1:0] st_x_reg;
    logic [COORD_W-1:0] st_y_reg;
    logic               move;

    // Output register.
    logic               m_valid_reg;
    logic [COORD_W-1:0] m_x_reg;
    logic [COORD_W-1:0] m_y_reg;
    row_colors_t        m_colors_reg;
    row_colors_t        colors_next;
    logic               m_clear_reg;
    logic               m_last_reg;

    // Colour regs: user must write only while block is idle; unenforced.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= FG_RESET;
            bg_reg <= BG_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_FG_COLOR) begin
                fg_reg <= cfg_data;
            end else if (cfg_index == REG_BG_COLOR) begin
                bg_reg <= cfg_data;
            end
        end
    end

    // Cursor flags and status.
    assign status.col_last   = (col_reg == CURSOR_W'(TEXT_COLUMNS - 1));
    assign status.row_last   = (row_reg == CURSOR_W'(TEXT_ROWS - 1));
    assign status.sweep_last = (sweep_reg == ADDR_W'(STORE_DEPTH - 1));
    assign move              = st_valid_reg && (!m_valid_reg || m_ready);
    assign status.stage_free = !st_valid_reg || move;

    // Cursor update: a column step off the last column becomes a new line,
    // and a new line off the last row homes the cursor.
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.newline || (cmd.advance && status.col_last)) begin
            col_next = '0;
            row_next = status.row_last ? '0 : row_reg + CURSOR_W'(1);
        end else if (cmd.advance) begin
            col_next = col_reg + CURSOR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            sweep_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cmd.sweep_we) begin
                sweep_reg <= sweep_reg + ADDR_W'(1);
            end
        end
    end

    // Character of the item being drawn.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            code_reg <= s_char_code;
        end
    end

    // Font store: zeroed by the sweep, loaded one row per item.
    assign glyph_slot = code_reg[6:0] - FIRST_PRINTABLE[6:0];
    assign rd_addr    = {glyph_slot, cmd.row};
    assign mem_we     = cmd.sweep_we
                        || (cmd.load_we && (s_glyph_index < 7'(GLYPH_COUNT)));
    assign wr_addr    = cmd.sweep_we ? sweep_reg : {s_glyph_index, s_glyph_row};
    assign mem_wdata  = cmd.sweep_we ? 8'd0 : s_glyph_bits;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue_row) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Result stage: holds the row position while its glyph bits are read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (cmd.issue_row || cmd.issue_clear) begin
            st_valid_reg <= 1'b1;
        end else if (move) begin
            st_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue_row || cmd.issue_clear) begin
            st_clear_reg <= cmd.issue_clear;
            st_last_reg  <= cmd.last;
            st_x_reg     <= cmd.issue_clear ? '0 : {col_reg, 3'b000};
            st_y_reg     <= cmd.issue_clear ? '0 : {row_reg, cmd.row};
        end
    end

    // Colour expansion: bit 7 of the glyph row is the leftmost pixel.
    always_comb begin
        colors_next = '0;
        if (st_clear_reg) begin
            colors_next[0] = bg_reg;
        end else begin
            for (int p = 0; p < 8; p++) begin
                colors_next[p] = rd_data_reg[7 - p] ? fg_reg : bg_reg;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (move) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            m_x_reg      <= st_x_reg;
            m_y_reg      <= st_y_reg;
            m_colors_reg <= colors_next;
            m_clear_reg  <= st_clear_reg;
            m_last_reg   <= st_last_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_x      = m_x_reg;
    assign m_pixel_y      = m_y_reg;
    assign m_colors       = m_colors_reg;
    assign m_clear_screen = m_clear_reg;
    assign m_last         = m_last_reg;

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console glyph renderer testbench
// Drives character and font-row items into the renderer and checks every
// pixel-row and screen-clear result against a cycle-free model of the text
// cursor, the font store and the colour registers. A short table of directed
// items comes first, then phases of random item sequences under different
// colour settings and idling patterns, two of them with a long receiver
// hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module testbench;
    import tcgr_pkg::*;

    localparam int DIRECTED_COUNT = 25;
    localparam int PHASE_COUNT    = 6;
    localparam int PHASE_ITEMS    = 70;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PRINT_LIMIT    = 100;

    // How a directed item's results are obtained.
    typedef enum logic [1:0] {
        CHK_MODEL,  // from the predictor
        CHK_NONE,   // no result at all
        CHK_FILL    // eight rows of one colour from (x, y0) downwards
    } row_check_t;

    typedef struct packed {
        logic                op;
        logic [7:0]          code;
        logic [6:0]          gidx;
        logic [2:0]          grow;
        logic [7:0]          bits;
        row_check_t          check;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y0;
        logic [COLOR_W-1:0]  fill;
    } directed_item_t;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        row_colors_t        colors;
        logic               clear;
        logic               last;
    } pixel_row_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_op          = 1'b0;
    logic [7:0]           s_char_code   = '0;
    logic [6:0]           s_glyph_index = '0;
    logic [2:0]           s_glyph_row   = '0;
    logic [7:0]           s_glyph_bits  = '0;
    logic                 m_ready       = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [COLOR_W-1:0]   cfg_data      = '0;
    logic                 cfg_ready;
    logic                 s_ready;
    logic                 m_valid;
    logic [COORD_W-1:0]   m_pixel_x;
    logic [COORD_W-1:0]   m_pixel_y;
    logic [COLOR_W-1:0]   m_color0;
    logic [COLOR_W-1:0]   m_color1;
    logic [COLOR_W-1:0]   m_color2;
    logic [COLOR_W-1:0]   m_color3;
    logic [COLOR_W-1:0]   m_color4;
    logic [COLOR_W-1:0]   m_color5;
    logic [COLOR_W-1:0]   m_color6;
    logic [COLOR_W-1:0]   m_color7;
    logic                 m_clear_screen;
    logic                 m_last;

    // Predicted state of the block.
    logic [CURSOR_W-1:0] cur_col;
    logic [CURSOR_W-1:0] cur_row;
    logic [7:0]          glyph_rows [STORE_DEPTH];
    logic [COLOR_W-1:0]  fg_colour;
    logic [COLOR_W-1:0]  bg_colour;

    // Results predicted for the item in hand, then the queue of all awaited.
    pixel_row_t new_rows [GLYPH_LINES+1];
    int         new_rows_n;
    pixel_row_t pending_rows [$];

    directed_item_t directed_items [DIRECTED_COUNT];

    int errors     = 0;
    int rows_seen  = 0;
    int tx_pct     = 0;
    int rx_pct     = 0;
    int phase_sent = 0;
    bit hold_req   = 1'b0;

    text_console_glyph_renderer_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_char_code    (s_char_code),
        .s_glyph_index  (s_glyph_index),
        .s_glyph_row    (s_glyph_row),
        .s_glyph_bits   (s_glyph_bits),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_color0       (m_color0),
        .m_color1       (m_color1),
        .m_color2       (m_color2),
        .m_color3       (m_color3),
        .m_color4       (m_color4),
        .m_color5       (m_color5),
        .m_color6       (m_color6),
        .m_color7       (m_color7),
        .m_clear_screen (m_clear_screen),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Clock with a 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Print a mismatch and count it. Printing stops after a while so that a
    // badly broken block does not flood the log, but counting goes on.
    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= PRINT_LIMIT) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
    endtask

    // Move the cursor to the start of the next text row; past the bottom row
    // the screen is cleared in the background colour and the cursor homed.
    task automatic advance_line();
        pixel_row_t clr;
        cur_col = '0;
        cur_row = cur_row + 1'b1;
        if (cur_row >= TEXT_ROWS) begin
            clr = '0;
            clr.colors[0] = bg_colour;
            clr.clear = 1'b1;
            new_rows[new_rows_n] = clr;
            new_rows_n++;
            cur_row = '0;
        end
    endtask

    // Work out the results of one accepted item and queue them.
    task automatic predict_pixel_rows(input logic op, input logic [7:0] code,
                                      input logic [6:0] gidx, input logic [2:0] grow,
                                      input logic [7:0] bits);
        pixel_row_t row;
        logic [7:0] line;
        int base;
        new_rows_n = 0;
        if (op == OP_LOAD_ROW) begin
            if (gidx < GLYPH_COUNT) begin
                glyph_rows[(int'(gidx) * GLYPH_LINES + int'(grow)) % STORE_DEPTH] = bits;
            end
        end else if (code == CHAR_LF || code == CHAR_CR) begin
            advance_line();
        end else begin
            if (code >= FIRST_PRINTABLE && code <= LAST_PRINTABLE) begin
                base = (int'(code) - int'(FIRST_PRINTABLE)) * GLYPH_LINES;
                for (int r = 0; r < GLYPH_LINES; r++) begin
                    line = glyph_rows[(base + r) % STORE_DEPTH];
                    row = '0;
                    row.x = {cur_col, 3'b000};
                    row.y = {cur_row, 3'b000} + COORD_W'(r);
                    for (int p = 0; p < 8; p++) begin
                        row.colors[p] = line[7-p] ? fg_colour : bg_colour;
                    end
                    new_rows[new_rows_n] = row;
                    new_rows_n++;
                end
            end
            cur_col = cur_col + 1'b1;
            if (cur_col >= TEXT_COLUMNS) begin
                advance_line();
            end
        end
        if (new_rows_n > 0) begin
            new_rows[new_rows_n-1].last = 1'b1;
        end
        for (int i = 0; i < new_rows_n; i++) begin
            pending_rows.push_back(new_rows[i]);
        end
    endtask

    // Offer one item, after a random gap in the sender's idle phases, and
    // return once it has been accepted. Valid stays high afterwards.
    task automatic send_item(input logic op, input logic [7:0] code,
                             input logic [6:0] gidx, input logic [2:0] grow,
                             input logic [7:0] bits);
        int gap;
        gap = 0;
        while (tx_pct != 0 && $urandom_range(99) < tx_pct && gap < 40) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_char_code   <= code;
        s_glyph_index <= gidx;
        s_glyph_row   <= grow;
        s_glyph_bits  <= bits;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic put_item(input logic op, input logic [7:0] code,
                            input logic [6:0] gidx, input logic [2:0] grow,
                            input logic [7:0] bits);
        send_item(op, code, gidx, grow, bits);
        predict_pixel_rows(op, code, gidx, grow, bits);
        // Loads into slots the block ignores do not count towards the phase.
        if (op == OP_PUT_CHAR || gidx < GLYPH_COUNT) begin
            phase_sent++;
        end
    endtask

    // Put a character with random content in the fields it does not use.
    task automatic put_char(input logic [7:0] code);
        put_item(OP_PUT_CHAR, code, 7'($urandom), 3'($urandom), 8'($urandom));
    endtask

    function automatic logic [7:0] pick_printable();
        if ($urandom_range(1)) begin
            return FIRST_PRINTABLE + 8'($urandom_range(15));
        end
        return 8'($urandom_range(int'(FIRST_PRINTABLE), int'(LAST_PRINTABLE)));
    endfunction

    // A code that only advances the cursor: control codes other than the
    // line breaks, or the upper half of the byte range.
    function automatic logic [7:0] pick_other_code();
        logic [7:0] c;
        if ($urandom_range(1)) begin
            c = 8'($urandom_range(128, 255));
        end else begin
            c = 8'($urandom_range(31));
            if (c == CHAR_LF || c == CHAR_CR) begin
                c = c + 8'd1;
            end
        end
        return c;
    endfunction

    // One random sequence of items, mostly well formed.
    task automatic run_sequence();
        int kind;
        int len;
        logic [6:0] gidx;
        kind = $urandom_range(99);
        if (kind < 25) begin
            // Load a whole glyph, often among the low slots that text uses.
            case ($urandom_range(7))
                0:       gidx = 7'($urandom_range(GLYPH_COUNT, 127));
                1, 2, 3: gidx = 7'($urandom_range(15));
                default: gidx = 7'($urandom_range(GLYPH_COUNT - 1));
            endcase
            for (int r = 0; r < GLYPH_LINES; r++) begin
                put_item(OP_LOAD_ROW, 8'($urandom), gidx, 3'(r), 8'($urandom));
            end
        end else if (kind < 60) begin
            len = $urandom_range(1, 16);
            repeat (len) put_char(pick_printable());
        end else if (kind < 70) begin
            len = $urandom_range(1, 8);
            repeat (len) put_char($urandom_range(1) ? CHAR_LF : CHAR_CR);
        end else if (kind < 80) begin
            len = $urandom_range(1, 24);
            repeat (len) put_char(pick_other_code());
        end else if (kind < 90) begin
            len = $urandom_range(1, 6);
            repeat (len) begin
                put_item(1'($urandom), 8'($urandom), 7'($urandom), 3'($urandom),
                         8'($urandom));
            end
        end else begin
            // Run to the last column (and in some cases the last row first)
            // and finish with a printable, so the line wraps after drawing.
            if (kind >= 95) begin
                while (cur_row != TEXT_ROWS - 1) begin
                    put_char($urandom_range(1) ? CHAR_LF : CHAR_CR);
                end
            end
            while (cur_col != TEXT_COLUMNS - 1) put_char(pick_other_code());
            put_char(pick_printable());
        end
    endtask

    // Wait until every awaited result has arrived, then let the block settle.
    task automatic wait_for_results();
        int waited;
        waited = 0;
        while (pending_rows.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_rows.size() != 0) begin
            report_mismatch($sformatf("timed out with %0d results outstanding",
                                      pending_rows.size()));
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_colours(input logic [COLOR_W-1:0] fg,
                                 input logic [COLOR_W-1:0] bg);
        cfg_valid <= 1'b1;
        cfg_index <= REG_FG_COLOR;
        cfg_data  <= fg;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        fg_colour = fg;
        cfg_index <= REG_BG_COLOR;
        cfg_data  <= bg;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        bg_colour = bg;
        cfg_valid <= 1'b0;
    endtask

    function automatic directed_item_t stim_row(
        input logic op, input logic [7:0] code, input logic [6:0] gidx,
        input logic [2:0] grow, input logic [7:0] bits, input row_check_t check,
        input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y0,
        input logic [COLOR_W-1:0] fill);
        directed_item_t d;
        d.op = op;
        d.code = code;
        d.gidx = gidx;
        d.grow = grow;
        d.bits = bits;
        d.check = check;
        d.x = x;
        d.y0 = y0;
        d.fill = fill;
        return d;
    endfunction

    // Compare one accepted result with the oldest one awaited.
    task automatic check_pixel_row();
        pixel_row_t want;
        row_colors_t got_colors;
        got_colors = {m_color7, m_color6, m_color5, m_color4,
                      m_color3, m_color2, m_color1, m_color0};
        if (pending_rows.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with none awaited", rows_seen));
        end else begin
            want = pending_rows.pop_front();
            if (m_pixel_x !== want.x) begin
                report_mismatch($sformatf("result %0d pixel_x %0d, want %0d",
                                          rows_seen, m_pixel_x, want.x));
            end
            if (m_pixel_y !== want.y) begin
                report_mismatch($sformatf("result %0d pixel_y %0d, want %0d",
                                          rows_seen, m_pixel_y, want.y));
            end
            for (int p = 0; p < 8; p++) begin
                if (got_colors[p] !== want.colors[p]) begin
                    report_mismatch($sformatf("result %0d color%0d %h, want %h",
                                              rows_seen, p, got_colors[p],
                                              want.colors[p]));
                end
            end
            if (m_clear_screen !== want.clear) begin
                report_mismatch($sformatf("result %0d clear_screen %b, want %b",
                                          rows_seen, m_clear_screen, want.clear));
            end
            if (m_last !== want.last) begin
                report_mismatch($sformatf("result %0d last %b, want %b",
                                          rows_seen, m_last, want.last));
            end
        end
        rows_seen++;
    endtask

    // Result side: check each accepted item, then choose the next ready,
    // holding off for a long stretch when the stimulus asks for it.
    initial begin : result_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                check_pixel_row();
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (rx_pct == 0) || ($urandom_range(99) >= rx_pct);
            end
        end
    end

    // Hard limit on the length of the run.
    initial begin : run_limit
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        directed_item_t d;
        pixel_row_t fill_row;
        logic [COLOR_W-1:0] fg_pick;
        logic [COLOR_W-1:0] bg_pick;

        // Model state after reset.
        cur_col = '0;
        cur_row = '0;
        fg_colour = FG_RESET;
        bg_colour = BG_RESET;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            glyph_rows[i] = 8'h00;
        end

        // Directed items: never-loaded glyphs, loads to the extreme and the
        // ignored slots, codes that only move the cursor, both line breaks
        // and random-looking content in fields that an item does not use.
        directed_items[0]  = stim_row(OP_PUT_CHAR, 8'd33,  7'd0,   3'd0, 8'h00, CHK_FILL,
                                      9'd0,  9'd0,  BG_RESET);
        directed_items[1]  = stim_row(OP_LOAD_ROW, 8'd0,   7'd95,  3'd7, 8'hFF, CHK_NONE,
                                      9'd0,  9'd0,  16'h0);
        directed_items[2]  = stim_row(OP_LOAD_ROW, 8'd0,   7'd96,  3'd2, 8'hFF, CHK_NONE,
                                      9'd0,  9'd0,  16'h0);
        directed_items[3]  = stim_row(OP_LOAD_ROW, 8'd0,   7'd127, 3'd0, 8'hFF, CHK_NONE,
                                      9'd0,  9'd0,  16'h0);
        directed_items[4]  = stim_row(OP_PUT_CHAR, 8'd127, 7'd0,   3'd0, 8'h00, CHK_MODEL,
                                      9'd0,  9'd0,  16'h0);
        directed_items[5]  = stim_row(OP_PUT_CHAR, 8'd63,  7'd0,   3'd0, 8'h00, CHK_FILL,
                                      9'd16, 9'd0,  BG_RESET);
        directed_items[6]  = stim_row(OP_LOAD_ROW, 8'd0,   7'd0,   3'd0, 8'h80, CHK_NONE,
                                      9'd0,  9'd0,  16'h0);
        directed_items[7]  = stim_row(OP_LOAD_ROW, 8'd0,   7'd0,   3'd7, 8'h01, CHK_NONE,
                                      9'd0,  9'd0,  16'h0);
        directed_items[8]  = stim_row(OP_LOAD_ROW, 8'd0,   7'd0,   3'd3, 8'hA5, CHK_NONE,
                                      9'd0,  9'd0,  16'h0);
        directed_items[9]  = stim_row(OP_PUT_CHAR, 8'd32,  7'd0,   3'd0, 8'h00, CHK_MODEL,
                                      9'd0,  9'd0,  16'h0);
        directed_items[10] = stim_row(OP_PUT_CHAR, 8'd0,   7'd0,   3'd0, 8'h00, CHK_NONE,
                                      9'd0,  9'd0,  16'h0);
        directed_items[11] = stim_row(OP_PUT_CHAR, 8'd255, 7'd0,   3'd0, 8'h00, CHK_NONE,
                                      9'd0,  9'd0,  16'h0);
        directed_items[12] = stim_row(OP_PUT_CHAR, 8'd31,  7'd0,   3'd0, 8'h00, CHK_NONE,
                                      9'd0,  9'd0,  16'h0);
        directed_items[13] = stim_row(OP_PUT_CHAR, 8'd128, 7'd0,   3'd0, 8'h00, CHK_NONE,
                                      9'd0,  9'd0,  16'h0);
        directed_items[14] = stim_row(OP_PUT_CHAR, 8'd9,   7'd0,   3'd0, 8'h00, CHK_NONE,
                                      9'd0,  9'd0,  16'h0);
        directed_items[15] = stim_row(OP_PUT_CHAR, CHAR_LF, 7'd0,  3'd0, 8'h00, CHK_NONE,
                                      9'd0,  9'd0,  16'h0);
        directed_items[16] = stim_row(OP_PUT_CHAR, CHAR_CR, 7'd0,  3'd0, 8'h00, CHK_NONE,
                                      9'd0,  9'd0,  16'h0);
        directed_items[17] = stim_row(OP_PUT_CHAR, 8'd64,  7'd0,   3'd0, 8'h00, CHK_FILL,
                                      9'd0,  9'd16, BG_RESET);
        directed_items[18] = stim_row(OP_LOAD_ROW, 8'd0,   7'd32,  3'd4, 8'h3C, CHK_NONE,
                                      9'd0,  9'd0,  16'h0);
        directed_items[19] = stim_row(OP_PUT_CHAR, 8'd64,  7'd0,   3'd0, 8'h00, CHK_MODEL,
                                      9'd0,  9'd0,  16'h0);
        directed_items[20] = stim_row(OP_LOAD_ROW, 8'd0,   7'd94,  3'd1, 8'h7E, CHK_NONE,
                                      9'd0,  9'd0,  16'h0);
        directed_items[21] = stim_row(OP_PUT_CHAR, 8'd126, 7'd0,   3'd0, 8'h00, CHK_MODEL,
                                      9'd0,  9'd0,  16'h0);
        directed_items[22] = stim_row(OP_PUT_CHAR, 8'd96,  7'd127, 3'd7, 8'hFF, CHK_FILL,
                                      9'd24, 9'd16, BG_RESET);
        directed_items[23] = stim_row(OP_LOAD_ROW, 8'd255, 7'd64,  3'd0, 8'hFF, CHK_NONE,
                                      9'd0,  9'd0,  16'h0);
        directed_items[24] = stim_row(OP_PUT_CHAR, 8'd96,  7'd0,   3'd0, 8'h00, CHK_MODEL,
                                      9'd0,  9'd0,  16'h0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: the predictor keeps the state, and rows with a typed
        // expectation replace what it queued.
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            d = directed_items[i];
            send_item(d.op, d.code, d.gidx, d.grow, d.bits);
            predict_pixel_rows(d.op, d.code, d.gidx, d.grow, d.bits);
            if (d.check != CHK_MODEL) begin
                repeat (new_rows_n) void'(pending_rows.pop_back());
                if (d.check == CHK_FILL) begin
                    for (int r = 0; r < GLYPH_LINES; r++) begin
                        fill_row = '0;
                        fill_row.x = d.x;
                        fill_row.y = d.y0 + COORD_W'(r);
                        for (int p = 0; p < 8; p++) begin
                            fill_row.colors[p] = d.fill;
                        end
                        fill_row.last = (r == GLYPH_LINES - 1);
                        pending_rows.push_back(fill_row);
                    end
                end
            end
        end
        s_valid <= 1'b0;

        // Random phases, each under its own colours and idling pattern.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            wait_for_results();
            fg_pick = 16'($urandom);
            bg_pick = 16'($urandom);
            case (ph)
                0: write_colours(16'hFFFF, 16'h0000);
                1: write_colours(16'h0000, 16'hFFFF);
                4: write_colours(fg_pick, fg_pick);
                default: write_colours(fg_pick, bg_pick);
            endcase
            case (ph % 4)
                0: begin tx_pct = 0;  rx_pct = 0;  end
                1: begin tx_pct = 69; rx_pct = 0;  end
                2: begin tx_pct = 0;  rx_pct = 69; end
                default: begin tx_pct = 28; rx_pct = 28; end
            endcase
            // Long receiver hold-off while the sender keeps offering items.
            if (ph % 4 == 0) begin
                hold_req = 1'b1;
            end
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS) run_sequence();
            s_valid <= 1'b0;
        end

        wait_for_results();
        if (pending_rows.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_rows.size()));
        end
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
